[hdl/ptb_pkg.sv]
// Shared types, field widths and codes of the periodic timer bank.
package ptb_pkg;

   // Field widths of the stream payloads
   localparam int KIND_BITS     = 2;
   localparam int NOW_BITS      = 48;
   localparam int HANDLE_BITS   = 16;
   localparam int INTERVAL_BITS = 32;
   localparam int EV_BITS       = 3;
   localparam int SLOT_OUT_BITS = 4;

   localparam int IN_DATA_BITS  = 96;
   localparam int OUT_DATA_BITS = 24;

   // A 32-bit millisecond interval times 1000 always fits in 42 bits
   localparam int PERIOD_BITS   = 42;
   localparam int US_PER_MS     = 1000;

   // A tick reports at most this many fired slots
   localparam int MAX_RESULTS   = 16;
   localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);

   // Defaults of the top-level parameters
   localparam int DEF_SLOTS     = 16;
   localparam int DEF_TIME_BITS = 48;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_TICK = 2'd0,
      KIND_ADD  = 2'd1,
      KIND_DEL  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [EV_BITS-1:0] {
      EV_ADDED     = 3'd0,
      EV_FULL      = 3'd1,
      EV_DELETED   = 3'd2,
      EV_NOT_FOUND = 3'd3,
      EV_FIRED     = 3'd4,
      EV_IDLE      = 3'd5
   } event_type;

endpackage

[hdl/periodic_timer_bank.sv]
// Top level of the periodic timer bank: slot sequencer, shared adder and result register.
// Items are taken one at a time; the input is freed only when an item is done. A tick, a
//   failed add or a delete that finds nothing takes an accept step, one step per slot and
//   a closing step; an add or delete that hits slot k frees the input at that slot. The single
//   slot-store read port and the shared deadline adder/comparator set this pace; result stalls slow it.
// The first result of an item is registered on the output during the scan or in its closing step.
// Reset (synchronous, active high) clears all active bits, reads every handle as zero,
//   and empties the result register; periods and deadlines are not cleared.
module periodic_timer_bank #(
   parameter int SLOTS     = ptb_pkg::DEF_SLOTS,
   parameter int TIME_BITS = ptb_pkg::DEF_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: now_us[47:0], handle[63:48], interval_ms[95:64]
   input  logic [ptb_pkg::IN_DATA_BITS-1:0]    req_tdata,
   // tuser: kind[1:0]
   input  logic [ptb_pkg::KIND_BITS-1:0]       req_tuser,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: slot[3:0], fired_handle[19:4], zero pad[23:20]
   output logic [ptb_pkg::OUT_DATA_BITS-1:0]   rsp_tdata,
   // tuser: event_res[2:0]
   output logic [ptb_pkg::EV_BITS-1:0]         rsp_tuser,
   output logic                                rsp_tlast
);
   import ptb_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PAD_W = OUT_DATA_BITS - HANDLE_BITS - SLOT_OUT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Unpack the request fields
   logic [NOW_BITS-1:0]      req_now_us;
   logic [HANDLE_BITS-1:0]   req_handle;
   logic [INTERVAL_BITS-1:0] req_interval_ms;
   kind_type                 req_kind;

   assign req_now_us      = req_tdata[NOW_BITS-1:0];
   assign req_handle      = req_tdata[NOW_BITS+HANDLE_BITS-1:NOW_BITS];
   assign req_interval_ms = req_tdata[NOW_BITS+HANDLE_BITS+INTERVAL_BITS-1:
                                      NOW_BITS+HANDLE_BITS];
   assign req_kind        = kind_type'(req_tuser);

   // Sequencer and item registers
   state_type              state_ff;
   logic [IDX_W-1:0]       idx_ff;
   kind_type               kind_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [SLOTS-1:0]       active_ff;

   // One fired slot is held back until we know whether it is the last one
   logic                   pend_valid_ff;
   logic [IDX_W-1:0]       pend_slot_ff;
   logic [HANDLE_BITS-1:0] pend_handle_ff;

   // Result register
   logic                     rsp_valid_ff;
   event_type                rsp_ev_ff;
   logic [SLOT_OUT_BITS-1:0] rsp_slot_ff;
   logic [HANDLE_BITS-1:0]   rsp_handle_ff;
   logic                     rsp_last_ff;

   // Store read data for slot idx_ff
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [PERIOD_BITS-1:0] rd_period;
   logic [TIME_BITS-1:0]   rd_deadline_us;

   // Decisions of the current cycle
   logic                     out_free;
   logic                     last_slot;
   logic                     advance;
   logic                     item_done;
   logic                     emit;
   event_type                emit_ev;
   logic [SLOT_OUT_BITS-1:0] emit_slot;
   logic [HANDLE_BITS-1:0]   emit_handle;
   logic                     emit_last;
   logic                     wr_add;
   logic                     wr_deadline;
   logic                     clr_active;
   logic                     pend_load;
   logic [IDX_W-1:0]         rd_addr;

   // Shared adder and comparator
   logic [TIME_BITS-1:0] sum_a;
   logic [TIME_BITS-1:0] sum_b;
   logic [TIME_BITS-1:0] sum_us;
   logic                 due;
   logic                 handle_hit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_slot  = (idx_ff == IDX_W'(SLOTS - 1));
   assign handle_hit = (rd_handle == handle_ff);
   assign due        = active_ff[idx_ff] && (rd_deadline_us < now_ff)
                       && (cnt_ff < CNT_BITS'(MAX_RESULTS));

   // An add forms now + period; a fire moves the stored deadline by its period
   always_comb begin
      if (kind_ff == KIND_ADD) begin
         sum_a = now_ff;
         sum_b = TIME_BITS'(period_ff);
      end else begin
         sum_a = rd_deadline_us;
         sum_b = TIME_BITS'(rd_period);
      end
      sum_us = sum_a + sum_b;
   end

   always_comb begin
      advance     = 1'b0;
      item_done   = 1'b0;
      emit        = 1'b0;
      emit_ev     = EV_IDLE;
      emit_slot   = SLOT_OUT_BITS'(idx_ff);
      emit_handle = handle_ff;
      emit_last   = 1'b1;
      wr_add      = 1'b0;
      wr_deadline = 1'b0;
      clr_active  = 1'b0;
      pend_load   = 1'b0;

      unique case (state_ff)
         ST_SCAN: begin
            unique case (kind_ff)
               KIND_ADD: begin
                  // claim the lowest free slot
                  if (!active_ff[idx_ff]) begin
                     if (out_free) begin
                        emit      = 1'b1;
                        emit_ev   = EV_ADDED;
                        wr_add    = 1'b1;
                        item_done = 1'b1;
                     end
                  end else begin
                     advance = 1'b1;
                  end
               end
               KIND_DEL: begin
                  // first handle match, active or not
                  if (handle_hit) begin
                     if (out_free) begin
                        emit       = 1'b1;
                        emit_ev    = EV_DELETED;
                        clr_active = 1'b1;
                        item_done  = 1'b1;
                     end
                  end else begin
                     advance = 1'b1;
                  end
               end
               KIND_TICK: begin
                  if (due) begin
                     // push the held fire out, then hold this one
                     if (!pend_valid_ff || out_free) begin
                        emit        = pend_valid_ff;
                        emit_ev     = EV_FIRED;
                        emit_slot   = SLOT_OUT_BITS'(pend_slot_ff);
                        emit_handle = pend_handle_ff;
                        emit_last   = 1'b0;
                        pend_load   = 1'b1;
                        wr_deadline = 1'b1;
                        advance     = 1'b1;
                     end
                  end else begin
                     advance = 1'b1;
                  end
               end
               default: begin
                  item_done = 1'b1;
               end
            endcase
         end
         ST_FINISH: begin
            // close the item with its final result
            if (out_free) begin
               emit      = 1'b1;
               item_done = 1'b1;
               emit_slot = '0;
               unique case (kind_ff)
                  KIND_ADD: emit_ev = EV_FULL;
                  KIND_DEL: emit_ev = EV_NOT_FOUND;
                  default: begin
                     if (pend_valid_ff) begin
                        emit_ev     = EV_FIRED;
                        emit_slot   = SLOT_OUT_BITS'(pend_slot_ff);
                        emit_handle = pend_handle_ff;
                     end else begin
                        emit_ev     = EV_IDLE;
                        emit_handle = '0;
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Read one slot ahead while the current one advances; hold while stalled
   always_comb begin
      if (state_ff == ST_SCAN) begin
         if (advance && !last_slot) begin
            rd_addr = idx_ff + IDX_W'(1);
         end else begin
            rd_addr = idx_ff;
         end
      end else begin
         rd_addr = '0;
      end
   end

   ptb_store #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock          (clock),
      .reset          (reset),
      .wr_add         (wr_add),
      .wr_deadline    (wr_deadline),
      .wr_addr        (idx_ff),
      .wr_handle      (handle_ff),
      .wr_period      (period_ff),
      .wr_deadline_us (sum_us),
      .rd_addr        (rd_addr),
      .rd_handle      (rd_handle),
      .rd_period      (rd_period),
      .rd_deadline_us (rd_deadline_us)
   );

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && (req_kind != KIND_NONE)) begin
                  state_ff      <= ST_SCAN;
                  idx_ff        <= '0;
                  cnt_ff        <= '0;
                  pend_valid_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (item_done) begin
                  state_ff <= ST_IDLE;
               end else if (advance) begin
                  if (last_slot) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     idx_ff <= idx_ff + IDX_W'(1);
                  end
               end
            end
            ST_FINISH: begin
               if (item_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (wr_add) begin
            active_ff[idx_ff] <= 1'b1;
         end
         if (clr_active) begin
            active_ff[idx_ff] <= 1'b0;
         end
         if (pend_load) begin
            pend_valid_ff <= 1'b1;
            cnt_ff        <= cnt_ff + CNT_BITS'(1);
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item and result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff   <= req_kind;
         now_ff    <= TIME_BITS'(req_now_us);
         handle_ff <= req_handle;
         period_ff <= PERIOD_BITS'(req_interval_ms) * PERIOD_BITS'(US_PER_MS);
      end
      if (pend_load) begin
         pend_slot_ff   <= idx_ff;
         pend_handle_ff <= rd_handle;
      end
      if (emit) begin
         rsp_ev_ff     <= emit_ev;
         rsp_slot_ff   <= emit_slot;
         rsp_handle_ff <= emit_handle;
         rsp_last_ff   <= emit_last;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_handle_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/ptb_store.sv]
// Per-slot storage of handle, period and deadline with a registered read port.
module ptb_store #(
   parameter int SLOTS     = ptb_pkg::DEF_SLOTS,
   parameter int TIME_BITS = ptb_pkg::DEF_TIME_BITS,
   parameter int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   // write side: an add writes all three fields, a fire writes the deadline
   input  logic                             wr_add,
   input  logic                             wr_deadline,
   input  logic [IDX_W-1:0]                 wr_addr,
   input  logic [ptb_pkg::HANDLE_BITS-1:0]  wr_handle,
   input  logic [ptb_pkg::PERIOD_BITS-1:0]  wr_period,
   input  logic [TIME_BITS-1:0]             wr_deadline_us,
   // read side: data is registered and shows in the cycle after the address
   input  logic [IDX_W-1:0]                 rd_addr,
   output logic [ptb_pkg::HANDLE_BITS-1:0]  rd_handle,
   output logic [ptb_pkg::PERIOD_BITS-1:0]  rd_period,
   output logic [TIME_BITS-1:0]             rd_deadline_us
);
   import ptb_pkg::*;

   logic [HANDLE_BITS-1:0] handle_mem_ff   [SLOTS];
   logic [PERIOD_BITS-1:0] period_mem_ff   [SLOTS];
   logic [TIME_BITS-1:0]   deadline_mem_ff [SLOTS];
   logic [SLOTS-1:0]       written_ff;

   logic [HANDLE_BITS-1:0] rd_handle_ff;
   logic                   rd_written_ff;
   logic [PERIOD_BITS-1:0] rd_period_ff;
   logic [TIME_BITS-1:0]   rd_deadline_ff;

   always_ff @(posedge clock) begin
      if (wr_add) begin
         handle_mem_ff[wr_addr] <= wr_handle;
         period_mem_ff[wr_addr] <= wr_period;
      end
      if (wr_add || wr_deadline) begin
         deadline_mem_ff[wr_addr] <= wr_deadline_us;
      end
      rd_handle_ff   <= handle_mem_ff[rd_addr];
      rd_period_ff   <= period_mem_ff[rd_addr];
      rd_deadline_ff <= deadline_mem_ff[rd_addr];
   end

   // A handle never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_add) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_handle      = rd_written_ff ? rd_handle_ff : '0;
   assign rd_period      = rd_period_ff;
   assign rd_deadline_us = rd_deadline_ff;

endmodule

[hdl/ptb_checker.sv]
// Port-level checks of the periodic timer bank and their binding to the top level.
module ptb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [ptb_pkg::KIND_BITS-1:0]       req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ptb_pkg::OUT_DATA_BITS-1:0]   rsp_tdata,
   input logic [ptb_pkg::EV_BITS-1:0]         rsp_tuser,
   input logic                                rsp_tlast
);
   import ptb_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // a real command occupies the sequencer
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != KIND_NONE) |=> !req_tready)
      else $error("input ready right after a command transfer");

   // every result other than a fire ends its item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_ADDED || rsp_tuser == EV_FULL ||
                     rsp_tuser == EV_DELETED || rsp_tuser == EV_NOT_FOUND ||
                     rsp_tuser == EV_IDLE) |-> rsp_tlast)
      else $error("single result without tlast");

   // an idle tick carries no slot and no handle
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_IDLE) |-> (rsp_tdata == '0))
      else $error("idle tick result has payload");

   // a failed add or delete reports slot zero
   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_FULL || rsp_tuser == EV_NOT_FOUND) |->
         (rsp_tdata[SLOT_OUT_BITS-1:0] == '0))
      else $error("miss result with nonzero slot");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);
